### rtl/core/ccap_pkg.sv
package ccap_pkg;

    // Window geometry: five rows by five columns, four rows held in the line memory
    localparam int WIN       = 5;
    localparam int LINE_ROWS = WIN - 1;

    // Smallest frame side that the pass accepts
    localparam int MIN_DIM = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_CUTOFF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAR_CUTOFF  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT  = 2'd3;

    // Register values after reset
    localparam logic [3:0] RST_NEAR_CUTOFF = 4'd5;
    localparam logic [4:0] RST_FAR_CUTOFF  = 5'd0;
    localparam logic [7:0] RST_MAP_WIDTH   = 8'd80;
    localparam logic [7:0] RST_MAP_HEIGHT  = 8'd24;

    // Input item kinds
    localparam logic CMD_CELL = 1'b0;

    // One window column: bit k is the cell k rows above the newest row
    typedef logic [WIN-1:0] win_col_t;

    // Control handed to each window cell
    typedef struct packed {
        logic     shift;
        logic     col_ok;
        win_col_t row_mask;
    } cell_ctrl_t;

    // Wall counts of one window column: middle three rows, and all five rows
    typedef struct packed {
        logic [1:0] mid;
        logic [2:0] full;
    } cell_count_t;

endpackage

### rtl/core/ccap_ram.sv
module ccap_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ccap_window_cell.sv
module ccap_window_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccap_pkg::cell_ctrl_t   ctrl,
    input  ccap_pkg::win_col_t     col_in,
    output ccap_pkg::win_col_t     col_out,
    output ccap_pkg::cell_count_t  count
);
    import ccap_pkg::*;

    win_col_t col_reg;
    win_col_t seen;

    // Take the column from the neighbour on every transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // Drop cells that lie off the map, then count walls
    assign seen = col_reg & ctrl.row_mask & {WIN{ctrl.col_ok}};

    always_comb
    begin
        count.mid  = 2'(seen[1]) + 2'(seen[2]) + 2'(seen[3]);
        count.full = 3'(count.mid) + 3'(seen[0]) + 3'(seen[4]);
    end

endmodule

### rtl/core/cave_cellular_automaton_pass_core.sv
// One smoothing pass of a 4-5 rule cave automaton over a wall/floor map streamed in
// raster order, one cell per transfer. The block takes one item per clock cycle
// unless the output stalls; the line memory (MAX_WIDTH words of four bits, one write
// and one read per transfer) and the five-column chain of window cells both advance
// once per transfer. A result follows the item that completes its 5x5 window, which
// is the item 2*map_width+2 positions later in the stream, so the host follows each
// frame with that many flush items. Border cells always come out as wall; the frame
// size is taken at the first item of each frame, while the cutoffs apply at once.
// There is no clearing pass after reset: the first item may be sent straight away.
module cave_cellular_automaton_pass_core #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccap_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccap_pkg::CFG_DATA_W-1:0]    cfg_data,
    // map cells in
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               command,
    input  logic                               cell_is_wall,
    // smoothed cells out
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               out_is_wall,
    output logic [6:0]                         out_row,
    output logic [6:0]                         out_col,
    output logic                               frame_last
);
    import ccap_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);       // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);   // frame width
    localparam int HW = $clog2(MAX_HEIGHT + 1);  // frame height
    localparam int RW = $clog2(MAX_HEIGHT + 4);  // input row, flush rows included
    localparam int OW = $clog2(MAX_HEIGHT);      // output row

    // Configuration registers
    logic [3:0] near_cutoff_reg;
    logic [4:0] far_cutoff_reg;
    logic [7:0] map_width_reg;
    logic [7:0] map_height_reg;

    // Frame and position state
    logic [WW-1:0] frame_w_reg;
    logic [HW-1:0] frame_h_reg;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [OW-1:0] o_row_reg, o_row_next;
    logic [CW-1:0] o_col_reg, o_col_next;

    // Window stage
    logic          s1_valid_reg;
    logic [OW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_last_reg;
    logic          s1_border_reg;
    win_col_t      s1_row_mask_reg;
    logic [WIN-1:0] s1_col_mask_reg;

    // Output register
    logic       result_valid_reg;
    logic       out_is_wall_reg;
    logic [6:0] out_row_reg;
    logic [6:0] out_col_reg;
    logic       frame_last_reg;

    logic          cfg_xfer;
    logic          in_xfer;
    logic          s1_adv;
    logic          at_start;
    logic [WW-1:0] w_clamp, w_cur;
    logic [HW-1:0] h_clamp, h_cur;
    logic          in_map;
    logic          in_border;
    logic          cell_v;
    logic          emit;
    logic          o_last;
    logic          o_border;
    win_col_t      row_mask;
    logic [WIN-1:0] col_mask;
    logic [LINE_ROWS-1:0] line_rd;
    win_col_t      new_col;
    win_col_t      chain_col [WIN];
    cell_ctrl_t    cell_ctrl [WIN];
    cell_count_t   cell_cnt  [WIN];
    logic [3:0]    near_cnt;
    logic [4:0]    far_cnt;
    logic          s1_wall;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid & cfg_ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_cutoff_reg <= RST_NEAR_CUTOFF;
            far_cutoff_reg  <= RST_FAR_CUTOFF;
            map_width_reg   <= RST_MAP_WIDTH;
            map_height_reg  <= RST_MAP_HEIGHT;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                REG_NEAR_CUTOFF: near_cutoff_reg <= cfg_data[3:0];
                REG_FAR_CUTOFF:  far_cutoff_reg  <= cfg_data[4:0];
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data;
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data;
            endcase
        end
    end

    // Handshake: the window stage moves on when the output register frees up
    assign s1_adv     = !result_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s1_adv;
    assign in_xfer    = item_valid && item_ready;

    // Saturate the requested frame size
    always_comb
    begin
        if (map_width_reg < 8'(MIN_DIM))
            w_clamp = WW'(MIN_DIM);
        else if (32'(map_width_reg) > MAX_WIDTH)
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(map_width_reg);

        if (map_height_reg < 8'(MIN_DIM))
            h_clamp = HW'(MIN_DIM);
        else if (32'(map_height_reg) > MAX_HEIGHT)
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(map_height_reg);
    end

    // Latch the size on the first item of a frame
    assign at_start = (in_row_reg == '0) && (in_col_reg == '0);
    assign w_cur    = at_start ? w_clamp : frame_w_reg;
    assign h_cur    = at_start ? h_clamp : frame_h_reg;

    // Cell value entering the window: force the border, blank positions past the map
    assign in_map    = in_row_reg < RW'(h_cur);
    assign in_border = (in_row_reg == '0) || (in_row_reg == RW'(h_cur) - RW'(1))
                    || (in_col_reg == '0) || (WW'(in_col_reg) == w_cur - WW'(1));
    assign cell_v    = in_map && (in_border || (command == CMD_CELL && cell_is_wall));

    // A result leaves once the item two rows and two columns on has arrived
    assign emit = (in_row_reg > RW'(2)) || (in_row_reg == RW'(2) && in_col_reg >= CW'(2));

    // Position of the result and its off-map masks
    assign o_last   = (o_row_reg == OW'(h_cur - HW'(1))) && (WW'(o_col_reg) == w_cur - WW'(1));
    assign o_border = (o_row_reg == '0) || (o_row_reg == OW'(h_cur - HW'(1)))
                   || (o_col_reg == '0) || (WW'(o_col_reg) == w_cur - WW'(1));

    always_comb
    begin
        row_mask[0] = (HW + 1)'(o_row_reg) + (HW + 1)'(3) <= (HW + 1)'(h_cur);
        row_mask[1] = (HW + 1)'(o_row_reg) + (HW + 1)'(2) <= (HW + 1)'(h_cur);
        row_mask[2] = 1'b1;
        row_mask[3] = o_row_reg >= OW'(1);
        row_mask[4] = o_row_reg >= OW'(2);
        col_mask[0] = (WW + 1)'(o_col_reg) + (WW + 1)'(3) <= (WW + 1)'(w_cur);
        col_mask[1] = (WW + 1)'(o_col_reg) + (WW + 1)'(2) <= (WW + 1)'(w_cur);
        col_mask[2] = 1'b1;
        col_mask[3] = o_col_reg >= CW'(1);
        col_mask[4] = o_col_reg >= CW'(2);
    end

    // Advance the input and output raster counters
    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        o_row_next  = o_row_reg;
        o_col_next  = o_col_reg;
        if (in_xfer)
        begin
            if (emit && o_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
                o_row_next  = '0;
                o_col_next  = '0;
            end
            else
            begin
                if (WW'(in_col_reg) + WW'(1) >= w_cur)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
                if (emit)
                begin
                    if (WW'(o_col_reg) + WW'(1) >= w_cur)
                    begin
                        o_col_next = '0;
                        o_row_next = o_row_reg + OW'(1);
                    end
                    else
                    begin
                        o_col_next = o_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= '0;
            frame_h_reg <= '0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            o_row_reg   <= '0;
            o_col_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                frame_w_reg <= w_cur;
                frame_h_reg <= h_cur;
            end
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            o_row_reg  <= o_row_next;
            o_col_reg  <= o_col_next;
        end
    end

    // Line memory: four rows above the current one, one word per column
    ccap_ram #(
        .WIDTH (LINE_ROWS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (in_col_reg),
        .wdata (new_col[LINE_ROWS-1:0]),
        .raddr (in_col_next),
        .rdata (line_rd)
    );

    assign new_col = {line_rd, cell_v};

    // Chain of window columns, newest at cell zero
    for (genvar j = 0; j < WIN; j++)
    begin : g_cell
        assign cell_ctrl[j].shift    = in_xfer;
        assign cell_ctrl[j].col_ok   = s1_col_mask_reg[j];
        assign cell_ctrl[j].row_mask = s1_row_mask_reg;

        if (j == 0)
        begin : g_head
            ccap_window_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl[j]),
                .col_in  (new_col),
                .col_out (chain_col[j]),
                .count   (cell_cnt[j])
            );
        end
        else
        begin : g_body
            ccap_window_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl[j]),
                .col_in  (chain_col[j-1]),
                .col_out (chain_col[j]),
                .count   (cell_cnt[j])
            );
        end
    end

    // Window stage: hold the position while the window is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= emit;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_row_reg      <= o_row_reg;
            s1_col_reg      <= o_col_reg;
            s1_last_reg     <= o_last;
            s1_border_reg   <= o_border;
            s1_row_mask_reg <= row_mask;
            s1_col_mask_reg <= col_mask;
        end
    end

    // Sum the 3x3 and the cornerless 5x5 counts, then apply the rule
    assign near_cnt = 4'(cell_cnt[1].mid) + 4'(cell_cnt[2].mid) + 4'(cell_cnt[3].mid);
    assign far_cnt  = 5'(cell_cnt[0].mid) + 5'(cell_cnt[4].mid)
                    + 5'(cell_cnt[1].full) + 5'(cell_cnt[2].full) + 5'(cell_cnt[3].full);
    assign s1_wall  = s1_border_reg ? 1'b1
                    : ((near_cnt >= near_cutoff_reg) || (far_cnt <= far_cutoff_reg));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_is_wall_reg <= s1_wall;
            out_row_reg     <= 7'(s1_row_reg);
            out_col_reg     <= 7'(s1_col_reg);
            frame_last_reg  <= s1_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_is_wall  = out_is_wall_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign frame_last   = frame_last_reg;

endmodule

### rtl/core/ccap_checker.sv
module ccap_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [ccap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [ccap_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                             item_valid,
    input logic                             item_ready,
    input logic                             command,
    input logic                             cell_is_wall,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic                             out_is_wall,
    input logic [6:0]                       out_row,
    input logic [6:0]                       out_col,
    input logic                             frame_last
);

    logic       start_reg;
    logic [6:0] prev_row_reg;
    logic [6:0] prev_col_reg;
    logic       res_xfer;
    logic       cfg_seen;
    logic       item_seen;
    logic       pos_start_ok;
    logic       pos_step_ok;

    assign res_xfer  = result_valid && result_ready;
    assign cfg_seen  = cfg_valid && (cfg_index == cfg_index) && (cfg_data == cfg_data);
    assign item_seen = item_valid && item_ready && (command == command)
                    && (cell_is_wall == cell_is_wall);

    // Track the last transferred position and the start of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= 1'b1;
            prev_row_reg <= '0;
            prev_col_reg <= '0;
        end
        else if (res_xfer)
        begin
            start_reg    <= frame_last;
            prev_row_reg <= out_row;
            prev_col_reg <= out_col;
        end
    end

    assign pos_start_ok = (out_row == 7'd0) && (out_col == 7'd0);
    assign pos_step_ok  = ((out_row == prev_row_reg) && (out_col == prev_col_reg + 7'd1))
                       || ((out_row == prev_row_reg + 7'd1) && (out_col == 7'd0));

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_is_wall)
            && $stable(out_row) && $stable(out_col) && $stable(frame_last))
        else $error("stalled result changed before transfer");

    // A frame opens at the top left corner
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && start_reg |-> pos_start_ok)
        else $error("frame does not open at row 0, column 0");

    // Results follow raster order
    a_raster_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !start_reg |-> pos_step_ok)
        else $error("result position skips or repeats");

    // The last cell of a frame is a border cell, so it comes out as wall
    a_last_wall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |-> out_is_wall)
        else $error("last cell of frame is not wall");

    // The configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_seen || item_seen || !cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind cave_cellular_automaton_pass_core ccap_checker u_checker (.*);
